FILE: hdl/krc_pkg.sv
// ----------------------------------------------------------------------------
// krc_pkg
// Shared widths, reset values and register indexes of the k-ary tree
// range cover block.
// ----------------------------------------------------------------------------
package krc_pkg;

	localparam int NODE_W  = 6;   // leaf / node index width
	localparam int LEVEL_W = 3;   // tree level width
	localparam int FAN_W   = 5;   // fanout register width
	localparam int CFG_W   = 5;   // config data width, widest register

	localparam int LEAF_COUNT_DEF = 64;

	localparam logic [FAN_W-1:0]   FANOUT_RST    = FAN_W'(2);
	localparam logic [LEVEL_W-1:0] TOP_LEVEL_RST = LEVEL_W'(6);

	// config register indexes
	localparam logic CFG_FANOUT    = 1'b0;
	localparam logic CFG_TOP_LEVEL = 1'b1;

endpackage

FILE: hdl/kary_tree_range_cover_core.sv
// ----------------------------------------------------------------------------
// kary_tree_range_cover_core
// Emits the smallest set of k-ary tree nodes covering an inclusive leaf range,
// one (level, index) beat per cycle on an unstalled edge walk, with a last marker.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | range_from, range_to
//  out     | out_valid / out_ready| node_level, node_index, last, range_error
//  cfg     | cfg_we (no wait)     | cfg_index, cfg_data
//
// Per level the shared 6-step restoring divider runs once for each end of
// the range, then the walk emits the left edge, turns to the right edge and
// climbs. A reversed range yields a single error beat, with level and index
// zero and last set.
// in_ready is high only while idle. Output stalls hold the walk in place.
// Reset clears control state and loads fanout 2, top level 6.
module kary_tree_range_cover_core
	import krc_pkg::*;
#(
	parameter int LEAF_COUNT = LEAF_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [NODE_W-1:0]  range_from,
	input  logic [NODE_W-1:0]  range_to,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [LEVEL_W-1:0] node_level,
	output logic [NODE_W-1:0]  node_index,
	output logic               last,
	output logic               range_error,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	localparam logic [NODE_W-1:0] LEAF_MAX = NODE_W'(LEAF_COUNT - 1);
	localparam logic [2:0]        DIV_LAST = 3'(NODE_W - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ERR,
		ST_DIV_F,
		ST_DIV_T,
		ST_LO,
		ST_HI
	} state_t;

	state_t               state_q;
	logic [FAN_W-1:0]     fanout_q;
	logic [LEVEL_W-1:0]   top_level_q;
	logic [LEVEL_W-1:0]   level_q;
	logic [NODE_W-1:0]    from_q, to_q;
	logic [NODE_W-1:0]    qf_q, qt_q;
	logic [FAN_W-1:0]     rf_q, rt_q;
	logic [NODE_W-1:0]    dvd_q;
	logic [FAN_W-1:0]     rem_q;
	logic [2:0]           cnt_q;

	logic                 out_valid_q, last_q, err_q;
	logic [LEVEL_W-1:0]   lvl_out_q;
	logic [NODE_W-1:0]    idx_out_q;

	logic [FAN_W-1:0]     k, km1;
	logic [FAN_W:0]       trial;
	logic                 ge;
	logic [FAN_W-1:0]     rem_nx;
	logic [NODE_W-1:0]    dvd_nx;
	logic [NODE_W-1:0]    from_c, to_c;
	logic                 at_top, can_load, lo_go, hi_go, div_done, emit;

	always_comb begin
		k        = (fanout_q < FAN_W'(2)) ? FAN_W'(2) : fanout_q;
		km1      = k - FAN_W'(1);
		at_top   = (level_q == top_level_q);
		// shared divider step: shift in next dividend bit, trial subtract
		trial    = {rem_q, dvd_q[NODE_W-1]};
		ge       = (trial >= {1'b0, k});
		rem_nx   = ge ? FAN_W'(trial - {1'b0, k}) : trial[FAN_W-1:0];
		dvd_nx   = {dvd_q[NODE_W-2:0], ge};
		div_done = (cnt_q == DIV_LAST);
		from_c   = (range_from > LEAF_MAX) ? LEAF_MAX : range_from;
		to_c     = (range_to > LEAF_MAX) ? LEAF_MAX : range_to;
		can_load = !out_valid_q || out_ready;
		lo_go    = ((rf_q != '0) || at_top) && (from_q < to_q);
		hi_go    = ((rt_q != km1) || at_top) && (from_q < to_q);
		emit     = can_load && ((state_q == ST_ERR)
			|| ((state_q == ST_LO) && lo_go)
			|| ((state_q == ST_HI) && (hi_go || (from_q == to_q))));
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign node_level  = lvl_out_q;
	assign node_index  = idx_out_q;
	assign last        = last_q;
	assign range_error = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			fanout_q    <= FANOUT_RST;
			top_level_q <= TOP_LEVEL_RST;
			cnt_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_FANOUT:    fanout_q    <= cfg_data;
					CFG_TOP_LEVEL: top_level_q <= cfg_data[LEVEL_W-1:0];
					default:       ;
				endcase
			end

			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (from_c > to_c) begin
							state_q <= ST_ERR;
						end else begin
							from_q  <= from_c;
							to_q    <= to_c;
							level_q <= '0;
							dvd_q   <= from_c;
							rem_q   <= '0;
							cnt_q   <= '0;
							state_q <= ST_DIV_F;
						end
					end
				end
				ST_ERR: begin
					if (can_load) begin
						lvl_out_q   <= '0;
						idx_out_q   <= '0;
						last_q      <= 1'b1;
						err_q       <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_DIV_F: begin
					if (div_done) begin
						qf_q    <= dvd_nx;
						rf_q    <= rem_nx;
						dvd_q   <= to_q;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV_T;
					end else begin
						dvd_q <= dvd_nx;
						rem_q <= rem_nx;
						cnt_q <= cnt_q + 3'd1;
					end
				end
				ST_DIV_T: begin
					if (div_done) begin
						qt_q    <= dvd_nx;
						rt_q    <= rem_nx;
						cnt_q   <= '0;
						state_q <= ST_LO;
					end else begin
						dvd_q <= dvd_nx;
						rem_q <= rem_nx;
						cnt_q <= cnt_q + 3'd1;
					end
				end
				ST_LO: begin
					// left edge: emit until from is aligned to a parent
					if (lo_go) begin
						if (can_load) begin
							lvl_out_q   <= level_q;
							idx_out_q   <= from_q;
							last_q      <= 1'b0;
							err_q       <= 1'b0;
							from_q      <= from_q + NODE_W'(1);
							if (rf_q == km1) begin
								rf_q <= '0;
								qf_q <= qf_q + NODE_W'(1);
							end else begin
								rf_q <= rf_q + FAN_W'(1);
							end
						end
					end else begin
						state_q <= ST_HI;
					end
				end
				ST_HI: begin
					// right edge, then climb or finish on the shared node
					if (hi_go) begin
						if (can_load) begin
							lvl_out_q   <= level_q;
							idx_out_q   <= to_q;
							last_q      <= 1'b0;
							err_q       <= 1'b0;
							to_q        <= to_q - NODE_W'(1);
							if (rt_q == '0) begin
								rt_q <= km1;
								qt_q <= qt_q - NODE_W'(1);
							end else begin
								rt_q <= rt_q - FAN_W'(1);
							end
						end
					end else if (from_q != to_q) begin
						from_q  <= qf_q;
						to_q    <= qt_q;
						level_q <= level_q + LEVEL_W'(1);
						dvd_q   <= qf_q;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV_F;
					end else if (can_load) begin
						lvl_out_q   <= level_q;
						idx_out_q   <= from_q;
						last_q      <= 1'b1;
						err_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: hdl/krc_checker.sv
// ----------------------------------------------------------------------------
// krc_checker
// Port-level checks for kary_tree_range_cover_core, bound to the top level.
// ----------------------------------------------------------------------------
module krc_checker
	import krc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [LEVEL_W-1:0] node_level,
	input logic [NODE_W-1:0]  node_index,
	input logic               last,
	input logic               range_error
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(node_index) && $stable(node_level)
			&& $stable(last) && $stable(range_error))
		else $error("result beat changed while stalled");

	// busy right after a query is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("query accepted back to back");

	// no new query while a cover is still in flight
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("ready while cover unfinished");

	// error beat is a single zeroed, final beat
	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> last && node_level == '0 && node_index == '0)
		else $error("malformed error beat");

endmodule

bind kary_tree_range_cover_core krc_checker u_krc_checker (.*);
